// File: rtl/gbk_text_normalizer_top_assert.svh
// assertion macros for the gbk text normalizer
`ifndef GBK_TEXT_NORMALIZER_TOP_ASSERT_SVH
`define GBK_TEXT_NORMALIZER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GTN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbk normalizer: same-cycle check failed");

// next-cycle implication, checked outside reset
`define GTN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbk normalizer: next-cycle check failed");

`endif

// File: rtl/gtn_pkg.sv
// package with constants and types for the gbk text normalizer
package gtn_pkg;

    localparam int unsigned MAX_LEN = 1024;
    localparam int unsigned LEN_W   = 11;

    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] HIGH_BYTE   = 8'h80;
    localparam logic [7:0] LEAD_FW     = 8'hA3;
    localparam logic [7:0] LEAD_SYM_LO = 8'hA1;
    localparam logic [7:0] LEAD_SYM_HI = 8'hA9;
    localparam logic [7:0] FW_UP_LO    = 8'hC1;
    localparam logic [7:0] FW_UP_HI    = 8'hDA;
    localparam logic [7:0] FW_LOW_LO   = 8'hE1;
    localparam logic [7:0] FW_LOW_HI   = 8'hFA;
    localparam logic [7:0] FW_DIG_LO   = 8'hB0;
    localparam logic [7:0] FW_DIG_HI   = 8'hB9;
    localparam logic [7:0] CH_A_LOW    = 8'h61;
    localparam logic [7:0] CH_Z_LOW    = 8'h7A;
    localparam logic [7:0] CH_A_UP     = 8'h41;
    localparam logic [7:0] CH_Z_UP     = 8'h5A;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;

    // one result transaction
    typedef struct packed {
        logic [7:0]       data;
        logic             is_end;
        logic [LEN_W-1:0] length;
        logic             last;
    } result_t;

endpackage

// File: rtl/gbk_text_normalizer_top.sv
// gbk text normalizer: one input byte per transaction, normalized bytes out
//
// Takes a GBK string one byte per transaction (zero ends it) and gives the
// normalized bytes, each with the running length, plus a terminator result
// that carries the final length. An accepted byte goes into an input
// register; once the result queue has room, short logic decodes it
// against the pending lead byte and writes its zero, one or two results
// into a two-entry result queue whose head drives the output ports. One
// byte is taken per cycle as long as each yields at most one result and
// the output is not stalled; a passed-through double-byte pair puts two
// results into the queue, so the sustained rate is set by the single
// output port: one result per cycle while the output is not stalled.
module gbk_text_normalizer_top
    import gtn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       in_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             is_end,
    output logic [LEN_W-1:0] out_length,
    output logic             last_in_run
);

    localparam logic [LEN_W-1:0] MAX_LEN_C = LEN_W'(MAX_LEN);

    // input register
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;

    // decode state
    logic             lead_pending_reg, lead_pending_next;
    logic [7:0]       lead_byte_reg, lead_byte_next;
    logic [LEN_W-1:0] count_reg, count_next;

    // result queue
    result_t          slot0_reg, slot1_reg;
    logic [1:0]       fill_reg;

    logic             in_take;
    logic             out_take;
    logic             process;
    logic [1:0]       num_res;
    result_t          res0, res1;
    logic [7:0]       half;
    logic [LEN_W-1:0] len1, len2;

    // saturating length step
    function automatic logic [LEN_W-1:0] bump(input logic [LEN_W-1:0] c);
        bump = (c < MAX_LEN_C) ? c + LEN_W'(1) : c;
    endfunction

    // full-width letter or digit trail to half-width, zero when none
    function automatic logic [7:0] fw_to_hw(input logic [7:0] t);
        fw_to_hw = 8'h00;
        if (t inside {[FW_UP_LO:FW_UP_HI]})
            fw_to_hw = t - FW_UP_LO + CH_A_LOW;
        else if (t inside {[FW_LOW_LO:FW_LOW_HI]})
            fw_to_hw = t - FW_LOW_LO + CH_A_LOW;
        else if (t inside {[FW_DIG_LO:FW_DIG_HI]})
            fw_to_hw = t - FW_DIG_LO + CH_0;
    endfunction

    // handshakes
    assign out_valid = (fill_reg != 2'd0);
    assign out_take  = out_valid && !out_stall;
    assign process   = in_valid_reg && ((fill_reg == 2'd0) || ((fill_reg == 2'd1) && out_take));
    assign in_stall  = in_valid_reg && !process;
    assign in_take   = in_valid && !in_stall;

    // output ports from queue head
    assign out_byte    = slot0_reg.data;
    assign is_end      = slot0_reg.is_end;
    assign out_length  = slot0_reg.length;
    assign last_in_run = slot0_reg.last;

    assign half = fw_to_hw(in_byte_reg);
    assign len1 = bump(count_reg);
    assign len2 = bump(len1);

    // byte decode
    always_comb
    begin
        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        count_next        = count_reg;
        num_res           = 2'd0;
        res0              = '{data: 8'h00, is_end: 1'b0, length: len1, last: 1'b1};
        res1              = '{data: in_byte_reg, is_end: 1'b0, length: len2, last: 1'b1};
        if (process)
        begin
            if (in_byte_reg == 8'h00)
            begin
                res0              = '{data: 8'h00, is_end: 1'b1, length: count_reg, last: 1'b1};
                num_res           = 2'd1;
                lead_pending_next = 1'b0;
                lead_byte_next    = 8'h00;
                count_next        = '0;
            end
            else if (lead_pending_reg)
            begin
                lead_pending_next = 1'b0;
                lead_byte_next    = 8'h00;
                if ((lead_byte_reg == LEAD_FW) && (half != 8'h00))
                begin
                    res0.data  = half;
                    num_res    = 2'd1;
                    count_next = len1;
                end
                else if (!(lead_byte_reg inside {[LEAD_SYM_LO:LEAD_SYM_HI]}))
                begin
                    // pair passes unchanged
                    res0.data  = lead_byte_reg;
                    res0.last  = 1'b0;
                    num_res    = 2'd2;
                    count_next = len2;
                end
            end
            else if (in_byte_reg inside {CH_CR, CH_LF, CH_SPACE})
            begin
                num_res = 2'd0;
            end
            else if (in_byte_reg >= HIGH_BYTE)
            begin
                lead_pending_next = 1'b1;
                lead_byte_next    = in_byte_reg;
            end
            else if (in_byte_reg inside {[CH_A_LOW:CH_Z_LOW], [CH_0:CH_9]})
            begin
                res0.data  = in_byte_reg;
                num_res    = 2'd1;
                count_next = len1;
            end
            else if (in_byte_reg inside {[CH_A_UP:CH_Z_UP]})
            begin
                res0.data  = in_byte_reg + CASE_OFFSET;
                num_res    = 2'd1;
                count_next = len1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= 8'h00;
            count_reg        <= '0;
            fill_reg         <= 2'd0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (process)
                in_valid_reg <= 1'b0;
            lead_pending_reg <= lead_pending_next;
            lead_byte_reg    <= lead_byte_next;
            count_reg        <= count_next;
            if (process)
                fill_reg <= num_res;
            else if (out_take)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= in_byte;
        if (process)
        begin
            slot0_reg <= res0;
            slot1_reg <= res1;
        end
        else if (out_take)
        begin
            slot0_reg <= slot1_reg;
        end
    end

`include "gbk_text_normalizer_top_assert.svh"

    // queue never holds more than two results
    `GTN_ASSERT_NOW(a_fill_max, clk, rst_n, 1'b1, fill_reg != 2'd3)
    // a terminator result is zero and closes its run
    `GTN_ASSERT_NOW(a_end_shape, clk, rst_n, out_valid && is_end, (out_byte == 8'h00) && last_in_run)
    // a processed zero byte clears the count and the pending lead
    `GTN_ASSERT_NEXT(a_end_clears, clk, rst_n, process && (in_byte_reg == 8'h00),
                     (count_reg == '0) && !lead_pending_reg)
    // the length never passes its limit
    `GTN_ASSERT_NOW(a_len_sat, clk, rst_n, 1'b1, count_reg <= MAX_LEN_C)

endmodule
